// ----- src/crc32wf_pkg.sv -----
// Shared types, codes and the byte fold function of the CRC-32 word and fill engine.
package crc32wf_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned WordWidth = 16;
  localparam int unsigned CntWidth  = 16;
  localparam int unsigned ByteBits  = 8;

  localparam logic [CrcWidth-1:0] PolyReset = 32'hEDB88320;
  localparam logic [CrcWidth-1:0] CrcReset  = 32'hFFFFFFFF;
  localparam logic [ByteBits-1:0] FillByte  = 8'hFF;

  localparam logic CmdWord = 1'b0;
  localparam logic CmdFill = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HIGH = 5'b00010,
    ST_FILL = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_SPARE = 5'b10000
  } ctrl_state_e;

  typedef enum logic [1:0] {
    BYTE_LOW  = 2'b00,
    BYTE_HIGH = 2'b01,
    BYTE_FILL = 2'b10
  } byte_sel_e;

  typedef struct packed {
    logic      load;
    logic      fold;
    byte_sel_e byte_sel;
    logic      emit;
  } dp_cmd_t;

  typedef struct packed {
    logic last_q;
    logic cnt_one;
    logic out_busy;
  } dp_status_t;

  // Eight reflected shift-and-XOR steps for one byte, LSB first.
  function automatic logic [CrcWidth-1:0] fold_byte(
    input logic [CrcWidth-1:0] crc,
    input logic [ByteBits-1:0] data,
    input logic [CrcWidth-1:0] poly
  );
    logic [CrcWidth-1:0] r;
    r = crc ^ {{(CrcWidth-ByteBits){1'b0}}, data};
    for (int k = 0; k < ByteBits; k++) begin
      if (r[0]) begin
        r = (r >> 1) ^ poly;
      end else begin
        r = r >> 1;
      end
    end
    return r;
  endfunction

endpackage

// ----- src/crc32wf_datapath.sv -----
// CRC register, polynomial, held request fields, byte fold unit and result register.
module crc32wf_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [crc32wf_pkg::CrcWidth-1:0] cfg_wdata_i,
  input  logic [crc32wf_pkg::WordWidth-1:0] data_word_i,
  input  logic [crc32wf_pkg::CntWidth-1:0] run_count_i,
  input  logic                             start_req_i,
  input  logic [crc32wf_pkg::CrcWidth-1:0] seed_i,
  input  logic                             last_i,
  input  crc32wf_pkg::dp_cmd_t             cmd_i,
  output crc32wf_pkg::dp_status_t          status_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [crc32wf_pkg::CrcWidth-1:0] crc_value_o
);
  import crc32wf_pkg::*;

  logic [CrcWidth-1:0] crc_q, crc_d, poly_q, out_q, crc_base;
  logic [ByteBits-1:0] high_q, fold_data;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                last_q, out_valid_q, out_valid_d;

  always_comb begin
    crc_base = crc_q;
    if (cmd_i.load && start_req_i) begin
      crc_base = ~seed_i;
    end
    case (cmd_i.byte_sel)
      BYTE_LOW:  fold_data = data_word_i[ByteBits-1:0];
      BYTE_HIGH: fold_data = high_q;
      BYTE_FILL: fold_data = FillByte;
      default:   fold_data = FillByte;
    endcase
    crc_d = cmd_i.fold ? fold_byte(crc_base, fold_data, poly_q) : crc_base;

    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = run_count_i - CntWidth'(1);
    end else if (cmd_i.fold) begin
      cnt_d = cnt_q - CntWidth'(1);
    end

    out_valid_d = out_valid_q && !out_ready_i;
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q       <= CrcReset;
      poly_q      <= PolyReset;
      out_valid_q <= 1'b0;
      last_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        poly_q <= cfg_wdata_i;
      end
      if (cmd_i.load || cmd_i.fold) begin
        crc_q <= crc_d;
      end
      if (cmd_i.load) begin
        last_q <= last_i;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      high_q <= data_word_i[WordWidth-1:ByteBits];
    end
    cnt_q <= cnt_d;
    if (cmd_i.emit) begin
      out_q <= ~crc_d;
    end
  end

  assign status_o.last_q   = last_q;
  assign status_o.cnt_one  = (cnt_q == CntWidth'(1));
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign crc_value_o = out_q;

endmodule

// ----- src/crc32wf_ctrl.sv -----
// Sequencer stepping the datapath one byte a cycle while a request runs; schedules results.
module crc32wf_ctrl (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic                    cmd_i,
  input  logic [crc32wf_pkg::CntWidth-1:0] run_count_i,
  input  logic                    last_i,
  input  crc32wf_pkg::dp_status_t status_i,
  output crc32wf_pkg::dp_cmd_t    cmd_o
);
  import crc32wf_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        done, done_last;

  always_comb begin
    state_d        = state_q;
    cmd_o.load     = 1'b0;
    cmd_o.fold     = 1'b0;
    cmd_o.byte_sel = BYTE_FILL;
    cmd_o.emit     = 1'b0;
    done           = 1'b0;
    done_last      = status_i.last_q;
    in_ready_o     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        done_last  = last_i;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (cmd_i == CmdWord) begin
            cmd_o.fold     = 1'b1;
            cmd_o.byte_sel = BYTE_LOW;
            state_d        = ST_HIGH;
          end else if (run_count_i == '0) begin
            done = 1'b1;
          end else begin
            cmd_o.fold = 1'b1;
            if (run_count_i == CntWidth'(1)) begin
              done = 1'b1;
            end else begin
              state_d = ST_FILL;
            end
          end
        end
      end
      ST_HIGH: begin
        cmd_o.fold     = 1'b1;
        cmd_o.byte_sel = BYTE_HIGH;
        done           = 1'b1;
      end
      ST_FILL: begin
        cmd_o.fold = 1'b1;
        done       = status_i.cnt_one;
      end
      ST_EMIT: begin
        if (!status_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Result goes straight to the output register unless it is still held.
    if (done) begin
      state_d = ST_IDLE;
      if (done_last) begin
        if (status_i.out_busy) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.emit = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- src/crc32_word_and_fill_engine.sv -----
// Top level of the reflected CRC-32 engine for 16-bit words and 0xFF runs.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one request: cmd_i selects a
//   16-bit word append (low byte first) or a run of run_count_i 0xFF bytes.
//   start_req_i reloads the register from ~seed_i before the request's bytes.
//   A request with last_i set gives one result on the output channel
//   (out_valid_o/out_ready_i): crc_value_o, the inverted running register.
//   Write the polynomial (cfg_we_i/cfg_wdata_i) only while idle; unenforced.
// Timing:
//   The single shift-and-XOR unit folds one byte per cycle while a request
//   runs: a word's low byte on acceptance, then its high; a run's N bytes in
//   turn, none for N = 0. A result is registered as its request finishes, if
//   the output is free. Requests are taken only when the sequencer is idle.
// Reset:
//   Register goes to all ones, polynomial to 0xEDB88320, output empty.
// Stalls:
//   A waiting result sits in the output register while the next request is
//   taken and processed; if that request also finishes with last set before
//   the output is taken, the engine holds until the output register frees.
module crc32_word_and_fill_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        cmd_i,
  input  logic [15:0] data_word_i,
  input  logic [15:0] run_count_i,
  input  logic        start_req_i,
  input  logic [31:0] seed_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] crc_value_o
);
  import crc32wf_pkg::*;

  dp_cmd_t    dp_cmd;
  dp_status_t dp_status;

  crc32wf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .cmd_i       (cmd_i),
    .run_count_i (run_count_i),
    .last_i      (last_i),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  crc32wf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .data_word_i (data_word_i),
    .run_count_i (run_count_i),
    .start_req_i (start_req_i),
    .seed_i      (seed_i),
    .last_i      (last_i),
    .cmd_i       (dp_cmd),
    .status_o    (dp_status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .crc_value_o (crc_value_o)
  );

`ifndef SYNTHESIS
  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit |-> !(out_valid_o && !out_ready_i))
    else $error("result loaded over a held output");

  a_word_high_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && cmd_i == CmdWord) |=>
      (dp_cmd.fold && dp_cmd.byte_sel == BYTE_HIGH && !in_ready_o))
    else $error("word request did not fold its high byte next");

  a_emit_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit |=> out_valid_o)
    else $error("emitted result not presented");

  a_no_load_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.load |-> (in_valid_i && !dp_cmd.emit || in_valid_i && dp_cmd.emit && last_i))
    else $error("load without a request or stray emit");
`endif

endmodule
